// File: rtl/hid_boot_report_key_diff_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the HID boot report key differ
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef HID_BOOT_REPORT_KEY_DIFF_CORE_DEFINES_SVH
`define HID_BOOT_REPORT_KEY_DIFF_CORE_DEFINES_SVH

// plain property under the block clock
`define HBKD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication under the block clock
`define HBKD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/hbkd_pkg.sv
// ----------------------------------------------------------------------------
// HBKD package
// Types, constants and helpers shared by the HID boot report key differ.
// ----------------------------------------------------------------------------
package hbkd_pkg;

  localparam int KEY_SLOTS   = 6;
  localparam int SLOT_FIELDS = 6;
  localparam int SCAN_W      = 8;
  localparam int JOB_W       = 2 * KEY_SLOTS;
  localparam int JOB_IDX_W   = (JOB_W > 1) ? $clog2(JOB_W) : 1;
  localparam int FIFO_DEPTH  = 2;  // power of two
  localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W   = 2;

  localparam logic [SCAN_W-1:0] SCAN_BASE    = SCAN_W'(30);
  localparam logic [SCAN_W-1:0] SCAN_MIN_KEY = SCAN_W'(3);

  localparam logic [SCAN_W-1:0] KC30_RESET = SCAN_W'(14);
  localparam logic [SCAN_W-1:0] KC31_RESET = SCAN_W'(28);
  localparam logic [SCAN_W-1:0] KC32_RESET = SCAN_W'(152);

  typedef enum logic [1:0] {
    EV_KEY     = 2'd0,
    EV_UNKNOWN = 2'd1,
    EV_SYNC    = 2'd2
  } ev_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCAN30 = 2'd0,
    CFG_SCAN31 = 2'd1,
    CFG_SCAN32 = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic              transfer_ok;
    logic [SCAN_W-1:0] slot0;
    logic [SCAN_W-1:0] slot1;
    logic [SCAN_W-1:0] slot2;
    logic [SCAN_W-1:0] slot3;
    logic [SCAN_W-1:0] slot4;
    logic [SCAN_W-1:0] slot5;
  } rpt_t;

  typedef struct packed {
    logic [1:0]        event_kind;
    logic [SCAN_W-1:0] key_code;
    logic [SCAN_W-1:0] scan_code;
    logic              pressed;
    logic              last;
  } evt_t;

  // even bit: release of old slot, odd bit: press of new slot
  typedef struct packed {
    logic [JOB_W-1:0]             mask;
    logic [JOB_W-1:0][SCAN_W-1:0] codes;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [SCAN_W-1:0] map_scan(
    input logic [SCAN_W-1:0] sc,
    input logic [SCAN_W-1:0] kc30,
    input logic [SCAN_W-1:0] kc31,
    input logic [SCAN_W-1:0] kc32
  );
    logic [SCAN_W-1:0] kc;
    kc = '0;
    if (sc == SCAN_BASE) kc = kc30;
    else if (sc == SCAN_BASE + SCAN_W'(1)) kc = kc31;
    else if (sc == SCAN_BASE + SCAN_W'(2)) kc = kc32;
    return kc;
  endfunction

endpackage

// File: rtl/hid_boot_report_key_diff_core.sv
// ----------------------------------------------------------------------------
// HID boot report key differ, top level
// Turns boot keyboard reports into press, release and unknown-key events.
// ----------------------------------------------------------------------------
// channel   signals                          direction
// rpt       rpt_valid rpt_ready rpt          in, one report per request
// evt       evt_valid evt_ready evt          out, one event per request
// cfg       cfg_valid cfg_ready cfg_index    in, keycode register write
//           cfg_data
//
// A report giving k key changes yields k+1 events (13 at most), one per cycle
// unless stalled, paced by the back part's event walker. A failed transfer is
// taken and yields nothing. Reports queue two deep, so the next one is taken
// while events still drain; evt_ready low stalls the walker, then the queue.
// Reset (synchronous) clears the stored slots and loads the keycode defaults.
// ----------------------------------------------------------------------------
`include "hid_boot_report_key_diff_core_defines.svh"

module hid_boot_report_key_diff_core
  import hbkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 rpt_valid,
  output logic                 rpt_ready,
  input  rpt_t                 rpt,
  output logic                 evt_valid,
  input  logic                 evt_ready,
  output evt_t                 evt,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCAN_W-1:0]    cfg_data
);

  logic    q_push;
  logic    q_pop;
  job_t    push_job;
  job_t    pop_job;
  q_stat_t q_stat;

  hbkd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  hbkd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .pop_job  (pop_job),
    .stat     (q_stat)
  );

  hbkd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_stat    (q_stat),
    .q_job     (pop_job),
    .q_pop     (q_pop),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt)
  );

  `HBKD_ASSERT_IMP(a_no_push_full, q_push, !q_stat.full, "job pushed into a full queue")
  `HBKD_ASSERT_IMP(a_no_pop_empty, q_pop, !q_stat.empty, "job popped from an empty queue")
  `HBKD_ASSERT_IMP(a_key_mapped, evt_valid && (evt.event_kind == EV_KEY), evt.key_code != '0,
    "key event without a key code")
  `HBKD_ASSERT_IMP(a_last_on_sync, evt_valid, evt.last == (evt.event_kind == EV_SYNC),
    "last flag not on the sync event")

endmodule

// File: rtl/hbkd_front.sv
// ----------------------------------------------------------------------------
// HBKD front
// Accepts reports, compares good ones with the stored slots and queues a job.
// ----------------------------------------------------------------------------
module hbkd_front
  import hbkd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    rpt_valid,
  output logic    rpt_ready,
  input  rpt_t    rpt,
  input  q_stat_t q_stat,
  output logic    q_push,
  output job_t    q_job
);

  logic [KEY_SLOTS-1:0][SCAN_W-1:0] prev_slots;
  logic [KEY_SLOTS-1:0][SCAN_W-1:0] cur;
  logic [SLOT_FIELDS-1:0][SCAN_W-1:0] fields;
  logic [KEY_SLOTS-1:0] old_seen;
  logic [KEY_SLOTS-1:0] new_seen;

  assign fields = {rpt.slot5, rpt.slot4, rpt.slot3, rpt.slot2, rpt.slot1, rpt.slot0};

  always_comb begin
    cur = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (i < SLOT_FIELDS) cur[i] = fields[i];
    end
  end

  always_comb begin
    old_seen = '0;
    new_seen = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (cur[j] == prev_slots[i]) old_seen[i] = 1'b1;
        if (prev_slots[j] == cur[i]) new_seen[i] = 1'b1;
      end
    end
  end

  always_comb begin
    q_job = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      q_job.mask[2*i]    = (prev_slots[i] > SCAN_MIN_KEY) && !old_seen[i];
      q_job.mask[2*i+1]  = (cur[i] > SCAN_MIN_KEY) && !new_seen[i];
      q_job.codes[2*i]   = prev_slots[i];
      q_job.codes[2*i+1] = cur[i];
    end
  end

  assign rpt_ready = !q_stat.full;
  assign q_push    = rpt_valid && rpt_ready && rpt.transfer_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_slots <= '0;
    end else if (q_push) begin
      prev_slots <= cur;
    end
  end

endmodule

// File: rtl/hbkd_fifo.sv
// ----------------------------------------------------------------------------
// HBKD job queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module hbkd_fifo
  import hbkd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    pop_job,
  output q_stat_t stat
);

  job_t                  entries [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr;
  logic [FIFO_PTR_W-1:0] rptr;
  logic [FIFO_CNT_W-1:0] count;

  assign stat.full  = (count == FIFO_CNT_W'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign pop_job    = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) entries[wptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + FIFO_PTR_W'(1);
      if (pop)  rptr <= rptr + FIFO_PTR_W'(1);
      if (push && !pop)      count <= count + FIFO_CNT_W'(1);
      else if (pop && !push) count <= count - FIFO_CNT_W'(1);
    end
  end

endmodule

// File: rtl/hbkd_back.sv
// ----------------------------------------------------------------------------
// HBKD back
// Walks a queued job, maps scancodes and drives the registered event output.
// ----------------------------------------------------------------------------
module hbkd_back
  import hbkd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  q_stat_t              q_stat,
  input  job_t                 q_job,
  output logic                 q_pop,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SCAN_W-1:0]    cfg_data,
  output logic                 evt_valid,
  input  logic                 evt_ready,
  output evt_t                 evt
);

  logic [SCAN_W-1:0]            kc30;
  logic [SCAN_W-1:0]            kc31;
  logic [SCAN_W-1:0]            kc32;
  logic                         busy;
  logic                         busy_next;
  logic [JOB_W-1:0]             mask;
  logic [JOB_W-1:0]             mask_next;
  logic [JOB_W-1:0][SCAN_W-1:0] codes;
  logic [JOB_IDX_W-1:0]         idx;
  logic [JOB_W-1:0]             low_bit;
  logic [SCAN_W-1:0]            sc;
  logic [SCAN_W-1:0]            kc;
  logic                         adv;
  logic                         finish;
  evt_t                         item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kc30 <= KC30_RESET;
      kc31 <= KC31_RESET;
      kc32 <= KC32_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SCAN30: kc30 <= cfg_data;
        CFG_SCAN31: kc31 <= cfg_data;
        CFG_SCAN32: kc32 <= cfg_data;
        default: ;
      endcase
    end
  end

  // lowest pending change
  always_comb begin
    idx = '0;
    for (int i = JOB_W - 1; i >= 0; i--) begin
      if (mask[i]) idx = JOB_IDX_W'(i);
    end
  end

  assign low_bit = mask & (~mask + JOB_W'(1));
  assign sc      = codes[idx];
  assign kc      = map_scan(sc, kc30, kc31, kc32);

  always_comb begin
    item = '0;
    if (mask != '0) begin
      item.event_kind = (kc != '0) ? EV_KEY : EV_UNKNOWN;
      item.key_code   = kc;
      item.scan_code  = sc;
      item.pressed    = idx[0];
    end else begin
      item.event_kind = EV_SYNC;
      item.last       = 1'b1;
    end
  end

  assign adv    = !evt_valid || evt_ready;
  assign finish = busy && adv && (mask == '0);
  assign q_pop  = !q_stat.empty && (!busy || finish);

  always_comb begin
    busy_next = busy;
    mask_next = mask;
    if (q_pop) begin
      busy_next = 1'b1;
      mask_next = q_job.mask;
    end else if (finish) begin
      busy_next = 1'b0;
    end else if (busy && adv) begin
      mask_next = mask & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) codes <= q_job.codes;
    if (adv && busy) evt <= item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      mask      <= '0;
      evt_valid <= 1'b0;
    end else begin
      busy <= busy_next;
      mask <= mask_next;
      if (adv) evt_valid <= busy;
    end
  end

endmodule

// File: bench/tb_hid_boot_report_key_diff_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the HID boot report key differ
// Sends boot keyboard reports through the request channel, rewrites the
// scancode keymap between batches and checks every event, field by field,
// against a key-diff predictor or stim table. Sender gaps and receiver
// stalls vary by phase, with one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_hid_boot_report_key_diff_core;
  import hbkd_pkg::*;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam evt_t SYNC_EVT = '{EV_SYNC, 8'd0, 8'd0, 1'b0, 1'b1};
  localparam evt_t NO_EVT   = '0;

  typedef struct {
    logic        remap;
    logic [23:0] keymap;
    rpt_t        report;
    int          n_typed;
    evt_t        typed [3];
  } stim_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 rpt_valid = 1'b0;
  logic                 rpt_ready;
  rpt_t                 rpt = '0;
  logic                 evt_valid;
  logic                 evt_ready = 1'b0;
  evt_t                 evt;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SCAN_W-1:0]    cfg_data = '0;

  logic [7:0] held_slots [KEY_SLOTS];
  logic [7:0] keymap [3];
  evt_t       due_events [$];
  evt_t       want;
  stim_row_t  stim_table [22];

  int errors = 0;
  int reports_sent = 0;
  int events_checked = 0;
  int keymap_loads = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int evt_hold_req = 0;
  int evt_hold_left = 0;

  hid_boot_report_key_diff_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .rpt_valid (rpt_valid),
    .rpt_ready (rpt_ready),
    .rpt       (rpt),
    .evt_valid (evt_valid),
    .evt_ready (evt_ready),
    .evt       (evt),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [7:0] key_for(input logic [7:0] sc);
    if (sc >= SCAN_BASE && sc <= SCAN_BASE + 8'd2) return keymap[sc - SCAN_BASE];
    return 8'd0;
  endfunction

  function automatic bit in_slots(input logic [7:0] slots [KEY_SLOTS], input logic [7:0] sc);
    foreach (slots[i]) if (slots[i] == sc) return 1'b1;
    return 1'b0;
  endfunction

  task automatic queue_change(input logic [7:0] sc, input logic dir);
    logic [7:0] kc;
    evt_t       e;
    kc = key_for(sc);
    e.event_kind = (kc != 8'd0) ? EV_KEY : EV_UNKNOWN;
    e.key_code   = kc;
    e.scan_code  = sc;
    e.pressed    = dir;
    e.last       = 1'b0;
    due_events.push_back(e);
  endtask

  // for a good transfer, diff against the held slots if asked, then hold the new slots
  task automatic fold_report(input rpt_t r, input bit enqueue);
    logic [7:0] field [SLOT_FIELDS];
    logic [7:0] fresh [KEY_SLOTS];
    if (!r.transfer_ok) return;
    field = '{r.slot0, r.slot1, r.slot2, r.slot3, r.slot4, r.slot5};
    for (int i = 0; i < KEY_SLOTS; i++) fresh[i] = (i < SLOT_FIELDS) ? field[i] : 8'd0;
    if (enqueue) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (held_slots[i] > SCAN_MIN_KEY && !in_slots(fresh, held_slots[i]))
          queue_change(held_slots[i], 1'b0);
        if (fresh[i] > SCAN_MIN_KEY && !in_slots(held_slots, fresh[i]))
          queue_change(fresh[i], 1'b1);
      end
      due_events.push_back(SYNC_EVT);
    end
    held_slots = fresh;
  endtask

  function automatic logic [7:0] likely_scan();
    case ($urandom_range(9))
      0, 1:    return 8'($urandom_range(3));
      2, 3, 4: return SCAN_BASE + 8'($urandom_range(2));
      5, 6:    return 8'($urandom_range(8, 4));
      7:       return held_slots[$urandom_range(KEY_SLOTS - 1)];
      default: return 8'($urandom);
    endcase
  endfunction

  // mostly key rollover around the held slots, some noise and failed transfers
  function automatic rpt_t random_report();
    rpt_t       r;
    logic [7:0] pick [SLOT_FIELDS];
    int         roll;
    roll = $urandom_range(99);
    for (int i = 0; i < SLOT_FIELDS; i++) begin
      if (roll < 18) pick[i] = 8'($urandom);
      else if (i < KEY_SLOTS && $urandom_range(1) == 1) pick[i] = held_slots[i];
      else pick[i] = likely_scan();
    end
    r.transfer_ok = (roll < 8) ? 1'b0 : (roll < 18) ? 1'($urandom) : 1'b1;
    r.slot0 = pick[0];
    r.slot1 = pick[1];
    r.slot2 = pick[2];
    r.slot3 = pick[3];
    r.slot4 = pick[4];
    r.slot5 = pick[5];
    return r;
  endfunction

  task automatic send_report(input rpt_t r, input bit predicted);
    rpt       <= r;
    rpt_valid <= 1'b1;
    @(posedge clk);
    while (!rpt_ready) @(posedge clk);
    fold_report(r, predicted);
    reports_sent++;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      rpt_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
    end
  endtask

  task automatic drain(input int settle);
    rpt_valid <= 1'b0;
    @(posedge clk);
    while (due_events.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx != CFG_SPARE) keymap[idx] = data;
  endtask

  task automatic load_keycodes(input logic [7:0] k30, input logic [7:0] k31,
                               input logic [7:0] k32);
    write_reg(CFG_SCAN30, k30);
    write_reg(CFG_SCAN31, k31);
    write_reg(CFG_SCAN32, k32);
    write_reg(CFG_SPARE, 8'($urandom));
    cfg_valid <= 1'b0;
    keymap_loads++;
  endtask

  task automatic run_phase(input int count, input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_report(random_report(), 1'b1);
  endtask

  task automatic check_field(input string what, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, exp_v, got_v);
    end
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (evt_hold_req != 0) begin
        evt_hold_left = evt_hold_req;
        evt_hold_req  = 0;
      end
      if (evt_hold_left > 0) begin
        evt_hold_left--;
        evt_ready <= 1'b0;
      end else begin
        evt_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && evt_valid && evt_ready) begin
      if (due_events.size() == 0) begin
        errors++;
        $display("%0t: unexpected event, expected none, got %p", $time, evt);
      end else begin
        want = due_events.pop_front();
        check_field("event_kind", 8'(want.event_kind), 8'(evt.event_kind));
        check_field("key_code", want.key_code, evt.key_code);
        check_field("scan_code", want.scan_code, evt.scan_code);
        check_field("pressed", 8'(want.pressed), 8'(evt.pressed));
        check_field("last", 8'(want.last), 8'(evt.last));
        events_checked++;
      end
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("%0t: timeout with %0d events outstanding", $time, due_events.size());
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    foreach (held_slots[i]) held_slots[i] = 8'd0;
    keymap = '{KC30_RESET, KC31_RESET, KC32_RESET};
    stim_table = '{
      '{1'b0, 24'h0, {1'b1, 48'h0000_0000_0000}, 1, '{SYNC_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b0, 48'hFFFF_FFFF_FFFF}, 0, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h1E00_0000_0000}, 2,
        '{'{EV_KEY, 8'd14, 8'd30, 1'b1, 1'b0}, SYNC_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h0000_0000_0000}, 2,
        '{'{EV_KEY, 8'd14, 8'd30, 1'b0, 1'b0}, SYNC_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h1E1F_2000_0000}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h1F20_1E00_0000}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b0, 48'h1E1F_2004_0506}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h0102_0304_0000}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'hFFFF_FFFF_FFFF}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'hFFFF_FFFF_FFFF}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'hAAAA_AAAA_AAAA}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h5555_5555_5555}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h0404_0505_1E1E}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h1E1E_1F1F_2020}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h0303_0303_0303}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h04FF_1E1F_2021}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h1D21_2200_0000}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b0, 48'h0000_0000_0000}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h0000_0000_0000}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b1, 24'h00FF00, '0, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h1E1F_2000_0000}, -1, '{NO_EVT, NO_EVT, NO_EVT}},
      '{1'b0, 24'h0, {1'b1, 48'h0000_0000_0000}, -1, '{NO_EVT, NO_EVT, NO_EVT}}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_table[n]) begin
      if (stim_table[n].remap) begin
        drain(SETTLE_CYCLES);
        load_keycodes(stim_table[n].keymap[23:16], stim_table[n].keymap[15:8],
                      stim_table[n].keymap[7:0]);
      end else begin
        for (int k = 0; k < stim_table[n].n_typed; k++)
          due_events.push_back(stim_table[n].typed[k]);
        send_report(stim_table[n].report, stim_table[n].n_typed < 0);
      end
    end
    drain(SETTLE_CYCLES);

    load_keycodes(KC30_RESET, KC31_RESET, KC32_RESET);
    run_phase(70, 0, 0);
    drain(SETTLE_CYCLES);
    load_keycodes(8'd0, 8'd0, 8'd0);
    run_phase(60, 67, 0);
    drain(SETTLE_CYCLES);
    load_keycodes(8'hFF, 8'hFF, 8'hFF);
    run_phase(60, 0, 67);
    drain(SETTLE_CYCLES);
    load_keycodes(8'd1, 8'd128, 8'd255);
    run_phase(60, 18, 18);
    drain(SETTLE_CYCLES);

    // hold the receiver off so the report queue fills, then pause the sender
    load_keycodes(8'($urandom), 8'($urandom), 8'($urandom));
    evt_hold_req = 400;
    run_phase(24, 18, 18);
    drain(0);
    run_phase(24, 18, 18);
    drain(SETTLE_CYCLES);

    load_keycodes(8'($urandom), 8'($urandom), 8'($urandom));
    run_phase(60, 0, 67);
    drain(SETTLE_CYCLES);
    load_keycodes(KC30_RESET, KC31_RESET, KC32_RESET);
    run_phase(40, 0, 0);
    drain(SETTLE_CYCLES);

    $display("Covered %0d reports, %0d events checked, %0d keymap loads", reports_sent,
             events_checked, keymap_loads);
    $display("Idle mixes: none, sender gaps, receiver stalls, both, long receiver hold-off");
    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
